### sv/swtm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_pkg
// shared command and status types for the sliding window trimmed mean
// ----------------------------------------------------------------------------
package swtm_pkg;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic        REG_WINDOW_LEN = 1'b0;
    localparam logic        REG_TRIM_COUNT = 1'b1;

    typedef struct packed {
        logic accept;
        logic oread;
        logic ocap;
        logic inner;
        logic divld;
        logic div;
        logic load_out;
    } swtm_cmd_t;

    typedef struct packed {
        logic rdy;
        logic inner_last;
        logic outer_last;
        logic div_last;
        logic out_free;
    } swtm_sts_t;

endpackage

### sv/swtm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module swtm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/swtm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_ctrl
// sequencer for accept, rank counting over the window, division and output
// ----------------------------------------------------------------------------
module swtm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  swtm_pkg::swtm_sts_t sts,
    output swtm_pkg::swtm_cmd_t cmd
);
    import swtm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_OREAD  = 7'b0000010,
        S_OCAP   = 7'b0000100,
        S_INNER  = 7'b0001000,
        S_DIVLD  = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_OREAD;
                end
            end
            S_OREAD:
            begin
                if (sts.rdy)
                begin
                    cmd.oread  = 1'b1;
                    state_next = S_OCAP;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_OCAP:
            begin
                cmd.ocap   = 1'b1;
                state_next = S_INNER;
            end
            S_INNER:
            begin
                cmd.inner = 1'b1;
                if (sts.inner_last)
                begin
                    state_next = sts.outer_last ? S_DIVLD : S_OREAD;
                end
            end
            S_DIVLD:
            begin
                cmd.divld  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/swtm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swtm_dp
// sample ring, rank counting accumulator, restoring divider, output register
// ----------------------------------------------------------------------------
module swtm_dp #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [6:0]          window_len,
    input  logic [4:0]          trim_count,
    input  logic [31:0]         sample,
    input  swtm_pkg::swtm_cmd_t cmd,
    output swtm_pkg::swtm_sts_t sts,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [31:0]         trimmed_mean,
    output logic                ready_res
);
    import swtm_pkg::*;

    localparam int AW   = $clog2(WINDOW_MAX);
    localparam int CW   = $clog2(WINDOW_MAX + 1);
    localparam int SW   = CW + 1;
    localparam int SUMW = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int DCW  = $clog2(SUMW);

    logic [AW-1:0]                 wp_reg;
    logic [CW-1:0]                 fill_reg;
    logic [CW-1:0]                 w_reg, hi_reg, d_reg, i_reg, j_reg, jq_reg, rank_reg;
    logic [4:0]                    t_reg;
    logic                          rdy_reg;
    logic signed [SAMPLE_BITS-1:0] vi_reg;
    logic signed [SUMW-1:0]        sum_reg;
    logic [CW-1:0]                 rem_reg;
    logic [SUMW-1:0]               quo_reg;
    logic                          neg_reg;
    logic [DCW-1:0]                dcnt_reg;
    logic                          out_valid_reg;
    logic [31:0]                   mean_reg;
    logic                          rres_reg;

    logic [SAMPLE_BITS-1:0]        rdata;
    logic [AW-1:0]                 raddr;
    logic [CW-1:0]                 fill_next, w_next, rank_next;
    logic [5:0]                    twot;
    logic                          rdy_next, less, in_mid;
    logic signed [SAMPLE_BITS-1:0] rd_s;
    logic [CW:0]                   shifted;
    logic                          qbit;
    logic signed [SUMW-1:0]        mean_s;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] wp, input logic [CW-1:0] age);
        logic [SW-1:0] tmp;
        tmp = SW'(wp) - SW'(age);
        if (tmp[SW-1])
        begin
            tmp = tmp + SW'(WINDOW_MAX);
        end
        return AW'(tmp);
    endfunction

    swtm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.accept),
        .waddr (wp_reg),
        .wdata (sample[SAMPLE_BITS-1:0]),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign raddr = cmd.oread ? slot(wp_reg, i_reg) : slot(wp_reg, j_reg);
    assign rd_s  = $signed(rdata);

    always_comb
    begin
        fill_next = (32'(fill_reg) < WINDOW_MAX) ? fill_reg + 1'b1 : fill_reg;
        w_next    = (32'(window_len) > WINDOW_MAX) ? CW'(WINDOW_MAX) : CW'(window_len);
        twot      = {1'b0, trim_count} << 1;
        rdy_next  = (w_next != '0) && (fill_next >= w_next) && (32'(twot) < 32'(w_next));
        less      = (rd_s < vi_reg) || ((rd_s == vi_reg) && (jq_reg < i_reg));
        rank_next = rank_reg + CW'(less);
        in_mid    = (32'(rank_next) >= 32'(t_reg)) && (rank_next < hi_reg);
        shifted   = {rem_reg, quo_reg[SUMW-1]};
        qbit      = (shifted >= {1'b0, d_reg});
        mean_s    = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);
    end

    assign sts.rdy        = rdy_reg;
    assign sts.inner_last = (jq_reg == w_reg);
    assign sts.outer_last = (i_reg == w_reg);
    assign sts.div_last   = (dcnt_reg == DCW'(SUMW - 1));
    assign sts.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            rdy_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                wp_reg   <= (32'(wp_reg) == WINDOW_MAX - 1) ? '0 : wp_reg + 1'b1;
                fill_reg <= fill_next;
                rdy_reg  <= rdy_next;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            w_reg   <= w_next;
            t_reg   <= trim_count;
            hi_reg  <= w_next - CW'(trim_count);
            d_reg   <= w_next - CW'(twot);
            i_reg   <= CW'(1);
            sum_reg <= '0;
        end
        if (cmd.oread)
        begin
            j_reg <= CW'(1);
        end
        if (cmd.ocap)
        begin
            vi_reg   <= $signed(rdata);
            rank_reg <= '0;
            jq_reg   <= j_reg;
            j_reg    <= j_reg + 1'b1;
        end
        if (cmd.inner)
        begin
            jq_reg   <= j_reg;
            j_reg    <= j_reg + 1'b1;
            rank_reg <= rank_next;
            if (sts.inner_last)
            begin
                i_reg <= i_reg + 1'b1;
                if (in_mid)
                begin
                    sum_reg <= sum_reg + SUMW'(vi_reg);
                end
            end
        end
        if (cmd.divld)
        begin
            neg_reg  <= sum_reg[SUMW-1];
            quo_reg  <= sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        if (cmd.div)
        begin
            rem_reg  <= qbit ? CW'(shifted - {1'b0, d_reg}) : CW'(shifted);
            quo_reg  <= {quo_reg[SUMW-2:0], qbit};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            mean_reg <= rdy_reg ? 32'(mean_s) : '0;
            rres_reg <= rdy_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign trimmed_mean = mean_reg;
    assign ready_res    = rres_reg;

endmodule

### sv/sliding_window_trimmed_mean.sv
`timescale 1ns / 1ps
// when not ready an accepted sample goes straight to the result state; when ready
// each window sample is ranked over the single read port of the sample ring,
// the middle ranks are summed, and the bit serial divider forms the mean
// throughput: one transaction in flight; the next is taken once the result is registered
// reset: control, pointers, fill count and output valid clear; ring undefined until written
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean
// trimmed mean over the most recent samples with an apb register port
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] trimmed_mean,
    output logic        ready_res
);
    import swtm_pkg::*;

    logic [6:0] window_len_reg;
    logic [4:0] trim_count_reg;
    swtm_cmd_t  cmd;
    swtm_sts_t  sts;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= 7'd64;
            trim_count_reg <= 5'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_WINDOW_LEN: window_len_reg <= pwdata[6:0];
                REG_TRIM_COUNT: trim_count_reg <= pwdata[4:0];
                default:        window_len_reg <= window_len_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_WINDOW_LEN: prdata = CFG_DATA_W'(window_len_reg);
            REG_TRIM_COUNT: prdata = CFG_DATA_W'(trim_count_reg);
            default:        prdata = '0;
        endcase
    end

    swtm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    swtm_dp #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .window_len   (window_len_reg),
        .trim_count   (trim_count_reg),
        .sample       (sample),
        .cmd          (cmd),
        .sts          (sts),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .trimmed_mean (trimmed_mean),
        .ready_res    (ready_res)
    );

endmodule

### verif/sliding_window_trimmed_mean_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean_checker
// watches the sample and result channels and the register port, keeps its own
// copy of the window and configuration, and compares every result transaction
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] sample,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [31:0] trimmed_mean,
    input  logic        ready_res,
    output int          fail_count,
    output int          pending,
    output int          ready_seen
);
    import swtm_pkg::*;

    localparam int WMAX = 64;

    typedef struct packed {
        logic [31:0] mean;
        logic        rdy;
    } mean_result_t;

    logic signed [31:0] ring [WMAX];
    logic [5:0]         wr_ptr;
    int                 fill;
    logic [6:0]         win_len;
    logic [4:0]         trim;
    mean_result_t       expected_means [$];

    function automatic mean_result_t predict_mean(input int w_in, input int t, input int n_held,
                                                  input logic [5:0] ptr);
        logic signed [31:0] vals [WMAX];
        logic signed [31:0] v;
        longint             sum;
        int                 w, n, j;
        mean_result_t       r;
        w = (w_in > WMAX) ? WMAX : w_in;
        n = (n_held < w) ? n_held : w;
        for (int age = 1; age <= n; age++)
        begin
            v = ring[(ptr + WMAX - age) % WMAX];
            j = age - 1;
            while (j > 0 && vals[j-1] > v)
            begin
                vals[j] = vals[j-1];
                j--;
            end
            vals[j] = v;
        end
        r = '0;
        if (w > 0 && n_held >= w && 2 * t < w)
        begin
            sum = 0;
            for (int i = t; i < w - t; i++)
                sum += vals[i];
            r.mean = 32'(sum / longint'(w - 2 * t));
            r.rdy = 1'b1;
        end
        return r;
    endfunction

    assign pending = expected_means.size();

    always @(posedge clk or negedge rst_n)
    begin
        mean_result_t e;
        logic [5:0]   nptr;
        if (!rst_n)
        begin
            wr_ptr <= '0;
            fill <= 0;
            win_len <= 7'd64;
            trim <= 5'd1;
            fail_count <= 0;
            ready_seen <= 0;
            expected_means.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_WINDOW_LEN)
                    win_len <= pwdata[6:0];
                else
                    trim <= pwdata[4:0];
            end
            if (in_valid && !in_stall)
            begin
                ring[wr_ptr] = sample;
                nptr = wr_ptr + 6'd1;
                wr_ptr <= nptr;
                if (fill < WMAX)
                    fill <= fill + 1;
                expected_means.push_back(predict_mean(win_len, trim,
                                         (fill < WMAX) ? fill + 1 : fill, nptr));
            end
            if (out_valid && !out_stall)
            begin
                if (ready_res)
                    ready_seen <= ready_seen + 1;
                if (expected_means.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result transaction mean=%0d ready=%0b",
                                 $signed(trimmed_mean), ready_res);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_means.pop_front();
                    if (e.mean !== trimmed_mean || e.rdy !== ready_res)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected mean=%0d ready=%0b, got mean=%0d ready=%0b",
                                     $signed(e.mean), e.rdy, $signed(trimmed_mean), ready_res);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### verif/sliding_window_trimmed_mean_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean_tb
// drives directed and random samples through several window and trim
// settings with random idling on both channels; a checker scores the results
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean_tb;
    import swtm_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] sample = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] trimmed_mean;
    logic        ready_res;
    int          fail_count, pending, ready_seen;
    int          send_idle_pct, recv_idle_pct;
    int          sent;

    always #5 clk = ~clk;

    sliding_window_trimmed_mean dut (.*);

    sliding_window_trimmed_mean_checker chk (.*);

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    task automatic reg_write(input logic addr_sel, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {addr_sel, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_sample(input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(5))
            0: return 32'h8000_0000 + $urandom_range(3);
            1: return 32'h7fff_ffff - $urandom_range(3);
            2: return $urandom_range(200) - 100;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        #300_000_000;
        $display("sliding_window_trimmed_mean_tb NOT OK");
        $finish;
    end

    initial
    begin
        int wl, tc, cnt;
        sent = 0;
        send_idle_pct = 16;
        recv_idle_pct = 52;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        // directed: reset config, extremes of the sample
        for (int i = 0; i < 20; i++)
            send_sample(i % 2 ? 32'h8000_0000 : 32'h7fff_ffff);
        drain();
        reg_write(REG_WINDOW_LEN, 3);
        reg_write(REG_TRIM_COUNT, 1);
        send_sample(32'h7fff_ffff);
        send_sample(32'h8000_0000);
        send_sample(32'hffff_ffff);
        drain();
        // zero trim, trim too large, zero window, window too long
        reg_write(REG_TRIM_COUNT, 0);
        send_sample(32'd7);
        drain();
        reg_write(REG_TRIM_COUNT, 31);
        send_sample(32'd1);
        drain();
        reg_write(REG_WINDOW_LEN, 0);
        send_sample(32'd2);
        drain();
        reg_write(REG_WINDOW_LEN, 127);
        reg_write(REG_TRIM_COUNT, 1);
        send_sample(32'd3);
        drain();
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 4)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 16;
            end
            if (ph == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph % 4)
                0: begin wl = 3; tc = 1; end
                1: begin wl = 64; tc = 31; end
                2: begin wl = $urandom_range(3, 16); tc = $urandom_range(0, 8); end
                default: begin wl = $urandom_range(0, 127); tc = $urandom_range(0, 31); end
            endcase
            reg_write(REG_WINDOW_LEN, wl);
            reg_write(REG_TRIM_COUNT, tc);
            cnt = (wl > 16) ? 110 : 170;
            for (int i = 0; i < cnt; i++)
                send_sample(rand_sample());
            drain();
        end
        $display("run covered %0d samples over 12 random phases, %0d ready results",
                 sent, ready_seen);
        if (fail_count == 0)
            $display("sliding_window_trimmed_mean_tb OK");
        else
            $display("sliding_window_trimmed_mean_tb NOT OK");
        $finish;
    end
endmodule
